// File: hw/rtl/scc_source_component_count_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the source component counter
// Used by the checker; each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef SCC_SOURCE_COMPONENT_COUNT_DEFINES_SVH
`define SCC_SOURCE_COMPONENT_COUNT_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define SCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scc assertion failed");

// Next-cycle implication, masked while in reset.
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scc assertion failed");

// Check what the cycle after a reset cycle shows.
`define SCC_ASSERT_RST(label, cons) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("scc reset check failed");

`endif

// File: hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Types, command codes and default sizes for the source component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;
    localparam int FIELD_W       = 11;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [FIELD_W-1:0] node_count;
        logic [FIELD_W-1:0] edge_source;
        logic [FIELD_W-1:0] edge_target;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] source_components;
        logic [FIELD_W-1:0] component_count;
        logic               input_error;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR,
        ST_CNT_A, ST_CNT_B, ST_CNT_C,
        ST_PRE_A, ST_PRE_B,
        ST_PL_A, ST_PL_B, ST_PL_C,
        ST_ROOT, ST_ROOT_CHK,
        ST_ENT_A, ST_ENT_B, ST_ENT_C,
        ST_TOP, ST_EDGE_A, ST_EDGE_B,
        ST_POP, ST_SCC_A, ST_SCC_B, ST_AFTER, ST_RES_A, ST_RES_B,
        ST_INC_A, ST_INC_B, ST_INC_C, ST_INC_D,
        ST_SRC_A, ST_SRC_B, ST_DONE
    } state_t;

endpackage

// File: hw/rtl/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port RAM: one write, one registered read, read data holds.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/scc_core.sv
// ----------------------------------------------------------------------------
// scc_core
// Edge loader and Tarjan walk sequencer over the graph memories.
// ----------------------------------------------------------------------------
module scc_core #(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  scc_pkg::in_item_t in_item,
    output logic              res_valid,
    input  logic              res_ready,
    output scc_pkg::out_item_t res_item
);
    import scc_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int IW  = (ECW > NCW) ? ECW : NCW;
    localparam int CW  = (NCW > FIELD_W) ? NCW : FIELD_W;

    state_t state_reg, state_next;
    logic [NCW-1:0] ntot_reg, ntot_next;
    logic [ECW-1:0] ecnt_reg, ecnt_next;
    logic           drop_reg, drop_next;
    logic [NCW-1:0] vcnt_reg, vcnt_next;
    logic [NCW-1:0] ccnt_reg, ccnt_next;
    logic [NCW-1:0] nsp_reg, nsp_next;
    logic [NCW-1:0] csp_reg, csp_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [ECW-1:0] sum_reg, sum_next;
    logic [NW-1:0]  ev_reg, ev_next;
    logic [NW-1:0]  tu_reg, tu_next;
    logic [ECW-1:0] tnext_reg, tnext_next;
    logic [ECW-1:0] tend_reg, tend_next;
    logic [NCW-1:0] tlow_reg, tlow_next;
    logic [NCW-1:0] tvis_reg, tvis_next;
    logic [NCW-1:0] cs_reg, cs_next;
    logic [NCW-1:0] srcs_reg, srcs_next;

    // memory ports
    logic es_we, es_re, eg_we, eg_re, at_we, at_re;
    logic [EW-1:0] es_wa, es_ra, eg_wa, eg_ra, at_wa, at_ra;
    logic [NW-1:0] es_wd, es_rd, eg_wd, eg_rd, at_wd, at_rd;
    logic ast_we, ast_re;
    logic [NCW-1:0] ast_wa, ast_ra;
    logic [ECW-1:0] ast_wd, ast_rd;
    logic vo_we, vo_re, ll_we, ll_re, ci_we, ci_re;
    logic [NW-1:0] vo_wa, vo_ra, ll_wa, ll_ra, ci_wa, ci_ra;
    logic [NCW-1:0] vo_wd, vo_rd, ll_wd, ll_rd, ci_wd, ci_rd;
    logic os_we, os_re, hi_we, hi_re;
    logic [NW-1:0] os_wa, os_ra, hi_wa, hi_ra;
    logic os_wd, os_rd, hi_wd, hi_rd;
    logic ns_we, ns_re, cn_we, cn_re, cx_we, cx_re;
    logic [NW-1:0] ns_wa, ns_ra, cn_wa, cn_ra, cx_wa, cx_ra;
    logic [NW-1:0] ns_wd, ns_rd, cn_wd, cn_rd;
    logic [ECW-1:0] cx_wd, cx_rd;

    logic [CW-1:0]  cnt_w, src_w, dst_w, nt_w;
    logic           edge_bad;
    logic [NCW-1:0] vnew, ct_m1, csp_m1, nsp_m1;
    logic [CW-1:0]  srcs_w, ccnt_w;

    scc_ram #(.DATA_W(NW), .DEPTH(MAX_EDGES)) u_es (.clk(aclk), .wr_en(es_we),
        .wr_addr(es_wa), .wr_data(es_wd), .rd_en(es_re), .rd_addr(es_ra), .rd_data(es_rd));
    scc_ram #(.DATA_W(NW), .DEPTH(MAX_EDGES)) u_eg (.clk(aclk), .wr_en(eg_we),
        .wr_addr(eg_wa), .wr_data(eg_wd), .rd_en(eg_re), .rd_addr(eg_ra), .rd_data(eg_rd));
    scc_ram #(.DATA_W(NW), .DEPTH(MAX_EDGES)) u_at (.clk(aclk), .wr_en(at_we),
        .wr_addr(at_wa), .wr_data(at_wd), .rd_en(at_re), .rd_addr(at_ra), .rd_data(at_rd));
    scc_ram #(.DATA_W(ECW), .DEPTH(MAX_NODES + 1)) u_ast (.clk(aclk), .wr_en(ast_we),
        .wr_addr(ast_wa), .wr_data(ast_wd), .rd_en(ast_re), .rd_addr(ast_ra),
        .rd_data(ast_rd));
    scc_ram #(.DATA_W(NCW), .DEPTH(MAX_NODES)) u_vo (.clk(aclk), .wr_en(vo_we),
        .wr_addr(vo_wa), .wr_data(vo_wd), .rd_en(vo_re), .rd_addr(vo_ra), .rd_data(vo_rd));
    scc_ram #(.DATA_W(NCW), .DEPTH(MAX_NODES)) u_ll (.clk(aclk), .wr_en(ll_we),
        .wr_addr(ll_wa), .wr_data(ll_wd), .rd_en(ll_re), .rd_addr(ll_ra), .rd_data(ll_rd));
    scc_ram #(.DATA_W(NCW), .DEPTH(MAX_NODES)) u_ci (.clk(aclk), .wr_en(ci_we),
        .wr_addr(ci_wa), .wr_data(ci_wd), .rd_en(ci_re), .rd_addr(ci_ra), .rd_data(ci_rd));
    scc_ram #(.DATA_W(1), .DEPTH(MAX_NODES)) u_os (.clk(aclk), .wr_en(os_we),
        .wr_addr(os_wa), .wr_data(os_wd), .rd_en(os_re), .rd_addr(os_ra), .rd_data(os_rd));
    scc_ram #(.DATA_W(1), .DEPTH(MAX_NODES)) u_hi (.clk(aclk), .wr_en(hi_we),
        .wr_addr(hi_wa), .wr_data(hi_wd), .rd_en(hi_re), .rd_addr(hi_ra), .rd_data(hi_rd));
    scc_ram #(.DATA_W(NW), .DEPTH(MAX_NODES)) u_ns (.clk(aclk), .wr_en(ns_we),
        .wr_addr(ns_wa), .wr_data(ns_wd), .rd_en(ns_re), .rd_addr(ns_ra), .rd_data(ns_rd));
    scc_ram #(.DATA_W(NW), .DEPTH(MAX_NODES)) u_cn (.clk(aclk), .wr_en(cn_we),
        .wr_addr(cn_wa), .wr_data(cn_wd), .rd_en(cn_re), .rd_addr(cn_ra), .rd_data(cn_rd));
    scc_ram #(.DATA_W(ECW), .DEPTH(MAX_NODES)) u_cx (.clk(aclk), .wr_en(cx_we),
        .wr_addr(cx_wa), .wr_data(cx_wd), .rd_en(cx_re), .rd_addr(cx_ra), .rd_data(cx_rd));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ntot_reg  <= '0;
            ecnt_reg  <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ntot_reg  <= ntot_next;
            ecnt_reg  <= ecnt_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        vcnt_reg  <= vcnt_next;
        ccnt_reg  <= ccnt_next;
        nsp_reg   <= nsp_next;
        csp_reg   <= csp_next;
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
        ev_reg    <= ev_next;
        tu_reg    <= tu_next;
        tnext_reg <= tnext_next;
        tend_reg  <= tend_next;
        tlow_reg  <= tlow_next;
        tvis_reg  <= tvis_next;
        cs_reg    <= cs_next;
        srcs_reg  <= srcs_next;
    end

    assign cnt_w    = CW'(in_item.node_count);
    assign src_w    = CW'(in_item.edge_source);
    assign dst_w    = CW'(in_item.edge_target);
    assign nt_w     = CW'(ntot_reg);
    assign edge_bad = (src_w == '0) || (src_w > nt_w) || (dst_w == '0) || (dst_w > nt_w)
                      || (ecnt_reg == ECW'(MAX_EDGES));
    assign vnew     = vcnt_reg + NCW'(1);
    assign ct_m1    = ci_rd - NCW'(1);
    assign csp_m1   = csp_reg - NCW'(1);
    assign nsp_m1   = nsp_reg - NCW'(1);
    assign srcs_w   = CW'(srcs_reg);
    assign ccnt_w   = CW'(ccnt_reg);

    assign res_item.source_components = srcs_w[FIELD_W-1:0];
    assign res_item.component_count   = ccnt_w[FIELD_W-1:0];
    assign res_item.input_error       = drop_reg;

    always_comb begin
        state_next = state_reg;
        ntot_next  = ntot_reg;
        ecnt_next  = ecnt_reg;
        drop_next  = drop_reg;
        vcnt_next  = vcnt_reg;
        ccnt_next  = ccnt_reg;
        nsp_next   = nsp_reg;
        csp_next   = csp_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ev_next    = ev_reg;
        tu_next    = tu_reg;
        tnext_next = tnext_reg;
        tend_next  = tend_reg;
        tlow_next  = tlow_reg;
        tvis_next  = tvis_reg;
        cs_next    = cs_reg;
        srcs_next  = srcs_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        es_we = 1'b0; es_wa = '0; es_wd = '0; es_re = 1'b0; es_ra = '0;
        eg_we = 1'b0; eg_wa = '0; eg_wd = '0; eg_re = 1'b0; eg_ra = '0;
        at_we = 1'b0; at_wa = '0; at_wd = '0; at_re = 1'b0; at_ra = '0;
        ast_we = 1'b0; ast_wa = '0; ast_wd = '0; ast_re = 1'b0; ast_ra = '0;
        vo_we = 1'b0; vo_wa = '0; vo_wd = '0; vo_re = 1'b0; vo_ra = '0;
        ll_we = 1'b0; ll_wa = '0; ll_wd = '0; ll_re = 1'b0; ll_ra = '0;
        ci_we = 1'b0; ci_wa = '0; ci_wd = '0; ci_re = 1'b0; ci_ra = '0;
        os_we = 1'b0; os_wa = '0; os_wd = 1'b0; os_re = 1'b0; os_ra = '0;
        hi_we = 1'b0; hi_wa = '0; hi_wd = 1'b0; hi_re = 1'b0; hi_ra = '0;
        ns_we = 1'b0; ns_wa = '0; ns_wd = '0; ns_re = 1'b0; ns_ra = '0;
        cn_we = 1'b0; cn_wa = '0; cn_wd = '0; cn_re = 1'b0; cn_ra = '0;
        cx_we = 1'b0; cx_wa = '0; cx_wd = '0; cx_re = 1'b0; cx_ra = '0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_item.command)
                        CMD_BEGIN: begin
                            ntot_next = (cnt_w > CW'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                                 : NCW'(cnt_w);
                            ecnt_next = '0;
                            drop_next = 1'b0;
                        end
                        CMD_EDGE: begin
                            if (edge_bad) begin
                                drop_next = 1'b1;
                            end else begin
                                es_we = 1'b1;
                                es_wa = ecnt_reg[EW-1:0];
                                es_wd = NW'(src_w - CW'(1));
                                eg_we = 1'b1;
                                eg_wa = ecnt_reg[EW-1:0];
                                eg_wd = NW'(dst_w - CW'(1));
                                ecnt_next = ecnt_reg + ECW'(1);
                            end
                        end
                        CMD_FINISH: begin
                            idx_next   = '0;
                            vcnt_next  = '0;
                            ccnt_next  = '0;
                            nsp_next   = '0;
                            csp_next   = '0;
                            state_next = ST_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // clear visit, on-stack, incoming flags and the adjacency counts
            ST_CLR: begin
                ast_we = 1'b1;
                ast_wa = idx_reg[NCW-1:0];
                if (idx_reg < IW'(ntot_reg)) begin
                    vo_we = 1'b1; vo_wa = idx_reg[NW-1:0];
                    os_we = 1'b1; os_wa = idx_reg[NW-1:0];
                    hi_we = 1'b1; hi_wa = idx_reg[NW-1:0];
                    idx_next = idx_reg + IW'(1);
                end else begin
                    idx_next   = '0;
                    state_next = ST_CNT_A;
                end
            end
            ST_CNT_A: begin
                if (idx_reg == IW'(ecnt_reg)) begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_PRE_A;
                end else begin
                    es_re = 1'b1;
                    es_ra = idx_reg[EW-1:0];
                    state_next = ST_CNT_B;
                end
            end
            ST_CNT_B: begin
                ast_re = 1'b1;
                ast_ra = NCW'(es_rd) + NCW'(1);
                state_next = ST_CNT_C;
            end
            ST_CNT_C: begin
                ast_we = 1'b1;
                ast_wa = NCW'(es_rd) + NCW'(1);
                ast_wd = ast_rd + ECW'(1);
                idx_next   = idx_reg + IW'(1);
                state_next = ST_CNT_A;
            end
            ST_PRE_A: begin
                if (idx_reg > IW'(ntot_reg)) begin
                    idx_next   = '0;
                    state_next = ST_PL_A;
                end else begin
                    ast_re = 1'b1;
                    ast_ra = idx_reg[NCW-1:0];
                    state_next = ST_PRE_B;
                end
            end
            ST_PRE_B: begin
                sum_next = sum_reg + ast_rd;
                ast_we = 1'b1;
                ast_wa = idx_reg[NCW-1:0];
                ast_wd = sum_reg + ast_rd;
                idx_next   = idx_reg + IW'(1);
                state_next = ST_PRE_A;
            end
            // scatter targets; each start entry advances to the end of its range
            ST_PL_A: begin
                if (idx_reg == IW'(ecnt_reg)) begin
                    idx_next   = '0;
                    state_next = ST_ROOT;
                end else begin
                    es_re = 1'b1; es_ra = idx_reg[EW-1:0];
                    eg_re = 1'b1; eg_ra = idx_reg[EW-1:0];
                    state_next = ST_PL_B;
                end
            end
            ST_PL_B: begin
                ast_re = 1'b1;
                ast_ra = NCW'(es_rd);
                state_next = ST_PL_C;
            end
            ST_PL_C: begin
                at_we  = 1'b1;
                at_wa  = ast_rd[EW-1:0];
                at_wd  = eg_rd;
                ast_we = 1'b1;
                ast_wa = NCW'(es_rd);
                ast_wd = ast_rd + ECW'(1);
                idx_next   = idx_reg + IW'(1);
                state_next = ST_PL_A;
            end
            ST_ROOT: begin
                if (idx_reg == IW'(ntot_reg)) begin
                    idx_next   = '0;
                    state_next = ST_INC_A;
                end else begin
                    vo_re = 1'b1;
                    vo_ra = idx_reg[NW-1:0];
                    state_next = ST_ROOT_CHK;
                end
            end
            ST_ROOT_CHK: begin
                if (vo_rd == '0) begin
                    ev_next    = idx_reg[NW-1:0];
                    state_next = ST_ENT_A;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_ROOT;
                end
            end
            // edges of node v span [end of v-1, end of v)
            ST_ENT_A: begin
                ast_re = 1'b1;
                ast_ra = NCW'(ev_reg) - NCW'(1);
                state_next = ST_ENT_B;
            end
            ST_ENT_B: begin
                tnext_next = (ev_reg == '0) ? '0 : ast_rd;
                ast_re = 1'b1;
                ast_ra = NCW'(ev_reg);
                state_next = ST_ENT_C;
            end
            ST_ENT_C: begin
                tend_next = ast_rd;
                vcnt_next = vnew;
                vo_we = 1'b1; vo_wa = ev_reg; vo_wd = vnew;
                ll_we = 1'b1; ll_wa = ev_reg; ll_wd = vnew;
                os_we = 1'b1; os_wa = ev_reg; os_wd = 1'b1;
                ns_we = 1'b1; ns_wa = nsp_reg[NW-1:0]; ns_wd = ev_reg;
                cn_we = 1'b1; cn_wa = csp_reg[NW-1:0]; cn_wd = ev_reg;
                tu_next   = ev_reg;
                tlow_next = vnew;
                tvis_next = vnew;
                nsp_next  = nsp_reg + NCW'(1);
                csp_next  = csp_reg + NCW'(1);
                state_next = ST_TOP;
            end
            ST_TOP: begin
                if (tnext_reg < tend_reg) begin
                    at_re = 1'b1;
                    at_ra = tnext_reg[EW-1:0];
                    tnext_next = tnext_reg + ECW'(1);
                    state_next = ST_EDGE_A;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_EDGE_A: begin
                vo_re = 1'b1; vo_ra = at_rd;
                os_re = 1'b1; os_ra = at_rd;
                state_next = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                if (vo_rd == '0) begin
                    // descend: save the parent's edge cursor
                    cx_we = 1'b1;
                    cx_wa = csp_m1[NW-1:0];
                    cx_wd = tnext_reg;
                    ev_next    = at_rd;
                    state_next = ST_ENT_A;
                end else begin
                    if (os_rd && (vo_rd < tlow_reg)) begin
                        tlow_next = vo_rd;
                        ll_we = 1'b1; ll_wa = tu_reg; ll_wd = vo_rd;
                    end
                    state_next = ST_TOP;
                end
            end
            ST_POP: begin
                csp_next = csp_m1;
                if (tlow_reg == tvis_reg) begin
                    ccnt_next  = ccnt_reg + NCW'(1);
                    state_next = ST_SCC_A;
                end else begin
                    state_next = ST_AFTER;
                end
            end
            ST_SCC_A: begin
                ns_re = 1'b1;
                ns_ra = nsp_m1[NW-1:0];
                nsp_next   = nsp_m1;
                state_next = ST_SCC_B;
            end
            ST_SCC_B: begin
                os_we = 1'b1; os_wa = ns_rd; os_wd = 1'b0;
                ci_we = 1'b1; ci_wa = ns_rd; ci_wd = ccnt_reg;
                if ((ns_rd != tu_reg) && (nsp_reg != '0)) begin
                    state_next = ST_SCC_A;
                end else begin
                    state_next = ST_AFTER;
                end
            end
            ST_AFTER: begin
                if (csp_reg == '0) begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_ROOT;
                end else begin
                    cn_re = 1'b1; cn_ra = csp_m1[NW-1:0];
                    cx_re = 1'b1; cx_ra = csp_m1[NW-1:0];
                    state_next = ST_RES_A;
                end
            end
            ST_RES_A: begin
                ll_re  = 1'b1; ll_ra = cn_rd;
                vo_re  = 1'b1; vo_ra = cn_rd;
                ast_re = 1'b1; ast_ra = NCW'(cn_rd);
                state_next = ST_RES_B;
            end
            ST_RES_B: begin
                tu_next    = cn_rd;
                tnext_next = cx_rd;
                tend_next  = ast_rd;
                tvis_next  = vo_rd;
                if (tlow_reg < ll_rd) begin
                    ll_we = 1'b1; ll_wa = cn_rd; ll_wd = tlow_reg;
                end else begin
                    tlow_next = ll_rd;
                end
                state_next = ST_TOP;
            end
            ST_INC_A: begin
                if (idx_reg == IW'(ecnt_reg)) begin
                    idx_next   = '0;
                    srcs_next  = '0;
                    state_next = ST_SRC_A;
                end else begin
                    es_re = 1'b1; es_ra = idx_reg[EW-1:0];
                    eg_re = 1'b1; eg_ra = idx_reg[EW-1:0];
                    state_next = ST_INC_B;
                end
            end
            ST_INC_B: begin
                ci_re = 1'b1; ci_ra = es_rd;
                state_next = ST_INC_C;
            end
            ST_INC_C: begin
                cs_next = ci_rd;
                ci_re = 1'b1; ci_ra = eg_rd;
                state_next = ST_INC_D;
            end
            ST_INC_D: begin
                if (cs_reg != ci_rd) begin
                    hi_we = 1'b1; hi_wa = ct_m1[NW-1:0]; hi_wd = 1'b1;
                end
                idx_next   = idx_reg + IW'(1);
                state_next = ST_INC_A;
            end
            ST_SRC_A: begin
                if (idx_reg == IW'(ccnt_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    hi_re = 1'b1; hi_ra = idx_reg[NW-1:0];
                    state_next = ST_SRC_B;
                end
            end
            ST_SRC_B: begin
                if (!hi_rd) begin
                    srcs_next = srcs_reg + NCW'(1);
                end
                idx_next   = idx_reg + IW'(1);
                state_next = ST_SRC_A;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/scc_source_component_count.sv
// ----------------------------------------------------------------------------
// scc_source_component_count
// Counts strongly connected components and source components of a loaded graph.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries command items: begin (sets node count, drops the edge
//   list), add edge (source, target numbered from 1), finish (compute).
//   Begin and add edge give no result; loading runs at one item per cycle
//   while no finish is running. Out-of-range edges and edges past MAX_EDGES are
//   dropped and raise input_error in the next result.
//   Finish returns exactly one item on the m_ channel. It walks the graph
//   memories with Tarjan's method through an explicit call stack, in order:
//   clear sweep, count and prefix passes, edge scatter, the walk, the
//   cross-component edge scan and the source count. s_ready stays low
//   meanwhile.
//   The result sits in an output register; the core may take new load items
//   while it waits for m_ready, and a following finish runs but holds its own
//   result inside the core until the register drains.
//   Reset clears node and edge counts and the error flag; the stores need no
//   clearing pass since finish sweeps its own flags.
// ----------------------------------------------------------------------------
module scc_source_component_count #(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  scc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output scc_pkg::out_item_t m_data
);
    import scc_pkg::*;

    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    scc_core #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Take a new result whenever the output register is empty or draining.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the payload while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks for the source component counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "scc_source_component_count_defines.svh"

module scc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input scc_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input scc_pkg::out_item_t m_data
);
    import scc_pkg::*;

    `SCC_ASSERT_RST(a_reset_empty, !m_valid)

    `SCC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    `SCC_ASSERT_NOW(a_src_le_cnt, m_valid, m_data.source_components <= m_data.component_count)

    `SCC_ASSERT_NOW(a_dag_has_src, m_valid && (m_data.component_count != '0), m_data.source_components != '0)

    `SCC_ASSERT_NEXT(a_finish_busy, s_valid && s_ready && (s_data.command == CMD_FINISH), !s_ready)

endmodule

bind scc_source_component_count scc_checker u_scc_checker (.*);

// File: bench/tb_scc_source_component_count.sv
// ----------------------------------------------------------------------------
// tb_scc_source_component_count
// Loads directed graphs into the source component counter and checks every
// finish result against a Tarjan walk kept inside the bench. Directed tests
// hit the extremes and the drop cases, then random graphs run with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_scc_source_component_count;
    timeunit 1ns;
    timeprecision 1ps;

    import scc_pkg::*;

    localparam int NODE_CAP = 1024;
    localparam int EDGE_CAP = 4096;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Graph as seen by the bench: node count, kept edges, drop flag.
    int        graph_nodes;
    int        kept_src[$];
    int        kept_dst[$];
    bit        edge_dropped;
    out_item_t pending_counts[$];

    // Scratch for the walk; indexes are node numbers minus one.
    int adj_start[NODE_CAP+1];
    int adj_fill[NODE_CAP+1];
    int adj_tgt[EDGE_CAP];
    int visit_no[NODE_CAP];
    int low_no[NODE_CAP];
    int scc_of[NODE_CAP];
    bit on_path[NODE_CAP];
    bit entered[NODE_CAP];
    int path_stack[NODE_CAP];
    int frame_node[NODE_CAP];
    int frame_edge[NODE_CAP];
    int path_sp, frame_sp, visit_seq;

    int  mismatches = 0;
    int  random_sent = 0;
    bit  calm = 1'b0;
    int  cycles = 0;
    int  out_stall = 0;

    scc_source_component_count i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Abort on a hang.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** scc_source_component_count: FAILED **");
            $finish;
        end
    end

    // Push a node on both stacks and open its frame.
    function automatic void open_node(int v);
        visit_seq++;
        visit_no[v] = visit_seq;
        low_no[v] = visit_seq;
        path_stack[path_sp++] = v;
        on_path[v] = 1'b1;
        frame_node[frame_sp] = v;
        frame_edge[frame_sp] = adj_start[v];
        frame_sp++;
    endfunction

    // Tarjan walk over the kept edges, then count components nothing enters.
    function automatic out_item_t count_sources();
        out_item_t res;
        int n, e, u, w, x, p, comps, sources;
        n = graph_nodes;
        for (int i = 0; i <= n; i++) begin
            adj_start[i] = 0;
            adj_fill[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            visit_no[i] = 0;
            on_path[i] = 1'b0;
            entered[i] = 1'b0;
        end
        foreach (kept_src[k]) adj_start[kept_src[k]]++;
        for (int i = 1; i <= n; i++) adj_start[i] += adj_start[i-1];
        // adj_start[v] now starts node v's range
        for (int i = 0; i <= n; i++) adj_fill[i] = adj_start[i];
        foreach (kept_src[k]) begin
            adj_tgt[adj_fill[kept_src[k]-1]] = kept_dst[k] - 1;
            adj_fill[kept_src[k]-1]++;
        end
        adj_start[n] = kept_src.size();
        path_sp = 0;
        frame_sp = 0;
        visit_seq = 0;
        comps = 0;
        for (int r = 0; r < n; r++) begin
            if (visit_no[r] != 0) continue;
            open_node(r);
            while (frame_sp > 0) begin
                u = frame_node[frame_sp-1];
                if (frame_edge[frame_sp-1] < adj_start[u+1]) begin
                    w = adj_tgt[frame_edge[frame_sp-1]];
                    frame_edge[frame_sp-1]++;
                    if (visit_no[w] == 0)
                        open_node(w);
                    else if (on_path[w] && visit_no[w] < low_no[u])
                        low_no[u] = visit_no[w];
                end else begin
                    frame_sp--;
                    if (low_no[u] == visit_no[u]) begin
                        comps++;
                        do begin
                            x = path_stack[--path_sp];
                            on_path[x] = 1'b0;
                            scc_of[x] = comps;
                        end while (x != u && path_sp > 0);
                    end
                    if (frame_sp > 0) begin
                        p = frame_node[frame_sp-1];
                        if (low_no[u] < low_no[p]) low_no[p] = low_no[u];
                    end
                end
            end
        end
        // reuse entered[] as the "has an incoming cross edge" flag per component
        foreach (kept_src[k]) begin
            e = scc_of[kept_dst[k]-1];
            if (scc_of[kept_src[k]-1] != e) entered[e-1] = 1'b1;
        end
        sources = 0;
        for (int i = 0; i < comps; i++)
            if (!entered[i]) sources++;
        res.source_components = sources[FIELD_W-1:0];
        res.component_count = comps[FIELD_W-1:0];
        res.input_error = edge_dropped;
        return res;
    endfunction

    // Advance the bench's graph on one accepted item.
    function automatic void apply_item(in_item_t it);
        int s, t;
        s = it.edge_source;
        t = it.edge_target;
        case (it.command)
            CMD_BEGIN: begin
                graph_nodes = (it.node_count > NODE_CAP) ? NODE_CAP : it.node_count;
                kept_src.delete();
                kept_dst.delete();
                edge_dropped = 1'b0;
            end
            CMD_EDGE: begin
                if (s == 0 || s > graph_nodes || t == 0 || t > graph_nodes ||
                    kept_src.size() >= EDGE_CAP) begin
                    edge_dropped = 1'b1;
                end else begin
                    kept_src.insert(kept_src.size(), s);
                    kept_dst.insert(kept_dst.size(), t);
                end
            end
            CMD_FINISH: pending_counts.insert(pending_counts.size(), count_sources());
            default: ;
        endcase
    endfunction

    // Send one item; valid stays high after acceptance unless a gap follows.
    task automatic send_item(logic [1:0] cmd, int nodes, int src, int dst, bit no_gap = 0);
        in_item_t it;
        int gap;
        it.command = cmd;
        it.node_count = nodes[FIELD_W-1:0];
        it.edge_source = src[FIELD_W-1:0];
        it.edge_target = dst[FIELD_W-1:0];
        gap = (calm || no_gap) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        apply_item(it);
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic drain_counts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_counts.size() > 0) @(posedge aclk);
    endtask

    // Check each result item against the oldest expected count.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", m_data);
                end else begin
                    want = pending_counts.pop_front();
                    if (m_data.source_components !== want.source_components ||
                        m_data.component_count !== want.component_count ||
                        m_data.input_error !== want.input_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected src=%0d comps=%0d err=%0b, got src=%0d comps=%0d err=%0b",
                                     want.source_components, want.component_count,
                                     want.input_error, m_data.source_components,
                                     m_data.component_count, m_data.input_error);
                    end
                end
                out_stall = calm ? 0 : $urandom_range(0, 14);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_finish_before_begin();
        send_item(CMD_FINISH, 0, 0, 0);
    endtask

    task automatic test_extremes();
        // empty graph, drop on any edge
        send_item(CMD_BEGIN, 0, 2047, 2047);
        send_item(CMD_EDGE, 0, 1, 1);
        send_item(CMD_FINISH, 2047, 0, 0);
        // saturated node count, corner node numbers
        send_item(CMD_BEGIN, 2047, 0, 0);
        send_item(CMD_EDGE, 0, 1024, 1);
        send_item(CMD_EDGE, 2047, 1, 1024);
        send_item(CMD_EDGE, 0, 1024, 1024);
        send_item(CMD_EDGE, 0, 2, 1);
        send_item(CMD_FINISH, 0, 0, 0);
        // unknown command is ignored; repeated finish gives the same answer
        send_item(CMD_UNUSED, 2047, 2047, 2047);
        send_item(CMD_FINISH, 0, 0, 0);
        // three-node loop plus tail, then out-of-range endpoints
        send_item(CMD_BEGIN, 5, 0, 0);
        send_item(CMD_EDGE, 0, 1, 2);
        send_item(CMD_EDGE, 0, 2, 3);
        send_item(CMD_EDGE, 0, 3, 1);
        send_item(CMD_EDGE, 0, 3, 4);
        send_item(CMD_FINISH, 0, 0, 0);
        send_item(CMD_EDGE, 0, 6, 1);
        send_item(CMD_EDGE, 0, 1, 0);
        send_item(CMD_EDGE, 0, 0, 2047);
        send_item(CMD_FINISH, 0, 0, 0);
        // begin clears the drop flag
        send_item(CMD_BEGIN, 1, 0, 0);
        send_item(CMD_FINISH, 0, 0, 0);
    endtask

    task automatic test_random_graphs();
        int nodes, edges, pick, src, dst;
        while (random_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0) nodes = 0;
            else if (pick == 1) nodes = $urandom_range(1024, 2047);
            else nodes = $urandom_range(1, 24);
            send_item(CMD_BEGIN, nodes, $urandom_range(0, 2047), $urandom_range(0, 2047));
            random_sent++;
            if (nodes > NODE_CAP) nodes = NODE_CAP;
            edges = $urandom_range(0, 32);
            for (int i = 0; i < edges; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(CMD_UNUSED, $urandom_range(0, 2047),
                              $urandom_range(0, 2047), $urandom_range(0, 2047));
                    random_sent++;
                end
                if ($urandom_range(0, 9) == 0 || nodes == 0) begin
                    src = $urandom_range(0, 2047);
                    dst = $urandom_range(0, 2047);
                end else begin
                    src = $urandom_range(1, nodes);
                    dst = $urandom_range(1, nodes);
                end
                send_item(CMD_EDGE, $urandom_range(0, 2047), src, dst);
                random_sent++;
            end
            // hold the sender now and then until every result is back
            if ($urandom_range(0, 3) == 0) drain_counts();
            send_item(CMD_FINISH, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 2047));
            random_sent++;
            if ($urandom_range(0, 7) == 0) begin
                send_item(CMD_FINISH, 0, 0, 0);
                random_sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        graph_nodes = 0;
        edge_dropped = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_finish_before_begin();
        test_extremes();
        drain_counts();
        test_random_graphs();
        drain_counts();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_counts.size() == 0)
            $display("** scc_source_component_count: PASSED **");
        else
            $display("** scc_source_component_count: FAILED **");
        $finish;
    end

endmodule
